/* rtl/core/kald_pkg.sv */
package kald_pkg;

   localparam int MAX_LEXEME = 32;
   localparam int LEN_W      = $clog2(MAX_LEXEME + 1);
   localparam int IDX_W      = $clog2(MAX_LEXEME);

   localparam int KW_NUM   = 8;
   localparam int KW_CHARS = 6;

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_LESS   = 8'h3C;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;

   typedef enum logic [4:0] {
      TK_ENDFILE = 5'd0,
      TK_ERROR   = 5'd1,
      TK_IF      = 5'd2,
      TK_THEN    = 5'd3,
      TK_ELSE    = 5'd4,
      TK_END     = 5'd5,
      TK_REPEAT  = 5'd6,
      TK_UNTIL   = 5'd7,
      TK_READ    = 5'd8,
      TK_WRITE   = 5'd9,
      TK_ID      = 5'd10,
      TK_NUM     = 5'd11,
      TK_ASSIGN  = 5'd12,
      TK_EQ      = 5'd13,
      TK_LT      = 5'd14,
      TK_PLUS    = 5'd15,
      TK_MINUS   = 5'd16,
      TK_TIMES   = 5'd17,
      TK_OVER    = 5'd18,
      TK_LPAREN  = 5'd19,
      TK_RPAREN  = 5'd20,
      TK_SEMI    = 5'd21
   } token_kind_type;

   typedef enum logic [2:0] {
      SC_START   = 3'd0,
      SC_ASSIGN  = 3'd1,
      SC_COMMENT = 3'd2,
      SC_NUM     = 3'd3,
      SC_ID      = 3'd4
   } scan_type;

   typedef enum logic [1:0] {
      CT_IDLE,
      CT_EMIT,
      CT_REPASS
   } ctrl_type;

   // lexeme store write: also feeds the keyword tracker
   typedef struct packed {
      logic             wr;
      logic [IDX_W-1:0] addr;
      logic [7:0]       data;
   } lex_wr_type;

   // keywords, left-justified, zero padded
   localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_NUM] = '{
      {"else", 16'h0}, {"end", 24'h0}, {"if", 32'h0}, {"read", 16'h0},
      {"repeat"}, {"then", 16'h0}, {"until", 8'h0}, {"write", 8'h0}
   };
   localparam int KW_LEN [KW_NUM] = '{4, 3, 2, 4, 6, 4, 5, 5};
   localparam token_kind_type KW_KIND [KW_NUM] = '{
      TK_ELSE, TK_END, TK_IF, TK_READ, TK_REPEAT, TK_THEN, TK_UNTIL, TK_WRITE
   };

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic token_kind_type single_kind(input logic [7:0] c);
      token_kind_type k;
      case (c)
         CH_EQUAL:  k = TK_EQ;
         CH_LESS:   k = TK_LT;
         CH_PLUS:   k = TK_PLUS;
         CH_MINUS:  k = TK_MINUS;
         CH_STAR:   k = TK_TIMES;
         CH_SLASH:  k = TK_OVER;
         CH_LPAREN: k = TK_LPAREN;
         CH_RPAREN: k = TK_RPAREN;
         CH_SEMI:   k = TK_SEMI;
         default:   k = TK_ERROR;
      endcase
      return k;
   endfunction

endpackage

/* rtl/core/kald_lexeme_mem.sv */
module kald_lexeme_mem (
   input  logic                      clock,
   input  kald_pkg::lex_wr_type      wr,
   input  logic                      rd_en,
   input  logic [kald_pkg::IDX_W-1:0] rd_addr,
   output logic [7:0]                rd_data
);

   logic [7:0] mem [kald_pkg::MAX_LEXEME];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.wr) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/kald_kw_match.sv */
module kald_kw_match (
   input  logic                       clock,
   input  kald_pkg::lex_wr_type       wr,
   input  logic [kald_pkg::LEN_W-1:0] count,
   output kald_pkg::token_kind_type   word_kind
);

   logic [kald_pkg::KW_NUM-1:0] match_ff;
   logic [kald_pkg::KW_NUM-1:0] match_in;
   logic [kald_pkg::KW_NUM-1:0] hit;

   // per-keyword byte compare at the write position
   always_comb begin
      for (int k = 0; k < kald_pkg::KW_NUM; k++) begin
         hit[k] = 1'b0;
         if (int'(wr.addr) < kald_pkg::KW_LEN[k]) begin
            hit[k] = (kald_pkg::KW_TEXT[k][8*(kald_pkg::KW_CHARS-1-int'(wr.addr)) +: 8]
                      == wr.data);
         end
      end
   end

   always_comb begin
      match_in = match_ff;
      if (wr.wr) begin
         match_in = (wr.addr == '0) ? hit : (match_ff & hit);
      end
   end

   always_comb begin
      word_kind = kald_pkg::TK_ID;
      for (int k = 0; k < kald_pkg::KW_NUM; k++) begin
         if (match_ff[k] && (count == kald_pkg::LEN_W'(kald_pkg::KW_LEN[k]))) begin
            word_kind = kald_pkg::KW_KIND[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      match_ff <= match_in;
   end

endmodule

/* rtl/core/keyword_aware_lexer_dfa.sv */
// Lexical scanner with keyword lookup. Each request carries one source byte
// (req_tdata) or an end-of-input mark (req_tuser). A finished token of n
// lexeme bytes is streamed from the lexeme memory one byte per cycle while
// rsp_tready is high, through the memory's registered read (one item for a
// token with an empty lexeme); a byte that ends a token is then scanned again
// from the start state, which may start a second token. Requests are taken
// only between tokens, while no token is being streamed. Lexemes are clamped
// at MAX_LEXEME bytes.
module keyword_aware_lexer_dfa (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] char_in
   input  logic        req_tuser,  // [0] end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // [7:0] lexeme_byte, [12:8] lexeme_index,
                                   // [18:13] lexeme_length, [23:19] zero
   output logic [4:0]  rsp_tuser,  // [4:0] token_kind
   output logic        rsp_tlast
);

   localparam int LW = kald_pkg::LEN_W;
   localparam int IW = kald_pkg::IDX_W;

   kald_pkg::ctrl_type       ctrl_ff, ctrl_in;
   kald_pkg::scan_type       scan_ff, scan_in;
   logic [LW-1:0]            count_ff, count_in;
   logic [7:0]               byte_ff, byte_in;
   logic                     eof_ff, eof_in;
   logic                     repass_ff, repass_in;
   kald_pkg::token_kind_type kind_ff, kind_in;
   logic [LW-1:0]            len_ff, len_in;
   logic [LW-1:0]            rd_idx_ff, rd_idx_in;
   logic                     rd_valid_ff, rd_valid_in;
   logic [IW-1:0]            rdi_ff, rdi_in;

   logic                     out_valid_ff, out_valid_in;
   kald_pkg::token_kind_type out_kind_ff, out_kind_in;
   logic [7:0]               out_byte_ff, out_byte_in;
   logic [IW-1:0]            out_idx_ff, out_idx_in;
   logic [LW-1:0]            out_len_ff, out_len_in;
   logic                     out_last_ff, out_last_in;

   // scan pass
   logic                     pass_go;
   logic [7:0]               p_c;
   logic                     p_eof;
   kald_pkg::scan_type       p_scan;
   logic                     p_clr, p_save, p_em, p_rp;
   kald_pkg::token_kind_type p_kind;
   logic [LW-1:0]            p_base, p_after;
   logic                     p_wr;

   kald_pkg::lex_wr_type     lex_wr;
   kald_pkg::token_kind_type word_kind;
   logic [7:0]               mem_rdata;

   // emission
   logic                     out_free, empty_tok, rd_en, load_mem, load_empty;
   logic                     mem_last, emit_done;

   assign pass_go = ((ctrl_ff == kald_pkg::CT_IDLE) && req_tvalid) ||
                    (ctrl_ff == kald_pkg::CT_REPASS);
   assign p_c     = (ctrl_ff == kald_pkg::CT_REPASS) ? byte_ff : req_tdata;
   assign p_eof   = (ctrl_ff == kald_pkg::CT_REPASS) ? eof_ff : req_tuser;

   always_comb begin
      p_scan = scan_ff;
      p_clr  = 1'b0;
      p_save = 1'b0;
      p_em   = 1'b0;
      p_rp   = 1'b0;
      p_kind = kald_pkg::TK_ERROR;
      unique case (scan_ff)
         kald_pkg::SC_COMMENT: begin
            if (p_eof) begin
               p_scan = kald_pkg::SC_START;
               p_clr  = 1'b1;
               p_em   = 1'b1;
               p_kind = kald_pkg::TK_ENDFILE;
            end else if (p_c == kald_pkg::CH_RBRACE) begin
               p_scan = kald_pkg::SC_START;
            end
         end
         kald_pkg::SC_ASSIGN: begin
            p_scan = kald_pkg::SC_START;
            p_em   = 1'b1;
            if (!p_eof && (p_c == kald_pkg::CH_EQUAL)) begin
               p_save = 1'b1;
               p_kind = kald_pkg::TK_ASSIGN;
            end else begin
               p_rp   = 1'b1;
            end
         end
         kald_pkg::SC_NUM: begin
            if (!p_eof && kald_pkg::is_digit(p_c)) begin
               p_save = 1'b1;
            end else begin
               p_scan = kald_pkg::SC_START;
               p_em   = 1'b1;
               p_rp   = 1'b1;
               p_kind = kald_pkg::TK_NUM;
            end
         end
         kald_pkg::SC_ID: begin
            if (!p_eof && kald_pkg::is_alpha(p_c)) begin
               p_save = 1'b1;
            end else begin
               p_scan = kald_pkg::SC_START;
               p_em   = 1'b1;
               p_rp   = 1'b1;
               p_kind = word_kind;
            end
         end
         default: begin
            p_scan = kald_pkg::SC_START;
            p_clr  = 1'b1;
            if (p_eof) begin
               p_em   = 1'b1;
               p_kind = kald_pkg::TK_ENDFILE;
            end else if (kald_pkg::is_digit(p_c)) begin
               p_save = 1'b1;
               p_scan = kald_pkg::SC_NUM;
            end else if (kald_pkg::is_alpha(p_c)) begin
               p_save = 1'b1;
               p_scan = kald_pkg::SC_ID;
            end else if (p_c == kald_pkg::CH_COLON) begin
               p_save = 1'b1;
               p_scan = kald_pkg::SC_ASSIGN;
            end else if ((p_c == kald_pkg::CH_SPACE) || (p_c == kald_pkg::CH_TAB) ||
                         (p_c == kald_pkg::CH_LF)) begin
               p_scan = kald_pkg::SC_START;
            end else if (p_c == kald_pkg::CH_LBRACE) begin
               p_scan = kald_pkg::SC_COMMENT;
            end else begin
               p_save = 1'b1;
               p_em   = 1'b1;
               p_kind = kald_pkg::single_kind(p_c);
            end
         end
      endcase
   end

   assign p_base  = p_clr ? '0 : count_ff;
   assign p_wr    = p_save && (p_base < LW'(kald_pkg::MAX_LEXEME));
   assign p_after = p_base + LW'(p_wr);

   assign lex_wr.wr   = pass_go && p_wr;
   assign lex_wr.addr = p_base[IW-1:0];
   assign lex_wr.data = p_c;

   kald_lexeme_mem u_mem (
      .clock   (clock),
      .wr      (lex_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IW-1:0]),
      .rd_data (mem_rdata)
   );

   kald_kw_match u_kw (
      .clock     (clock),
      .wr        (lex_wr),
      .count     (count_ff),
      .word_kind (word_kind)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign empty_tok  = (len_ff == '0);
   assign rd_en      = (ctrl_ff == kald_pkg::CT_EMIT) && !empty_tok &&
                       (rd_idx_ff < len_ff) && (!rd_valid_ff || out_free);
   assign load_mem   = (ctrl_ff == kald_pkg::CT_EMIT) && rd_valid_ff && out_free;
   assign load_empty = (ctrl_ff == kald_pkg::CT_EMIT) && empty_tok && out_free;
   assign mem_last   = ((LW'(rdi_ff) + LW'(1)) == len_ff);
   assign emit_done  = load_empty || (load_mem && mem_last);

   always_comb begin
      ctrl_in = ctrl_ff;
      unique case (ctrl_ff)
         kald_pkg::CT_IDLE: begin
            if (req_tvalid && p_em) begin
               ctrl_in = kald_pkg::CT_EMIT;
            end
         end
         kald_pkg::CT_EMIT: begin
            if (emit_done) begin
               ctrl_in = repass_ff ? kald_pkg::CT_REPASS : kald_pkg::CT_IDLE;
            end
         end
         kald_pkg::CT_REPASS: begin
            ctrl_in = p_em ? kald_pkg::CT_EMIT : kald_pkg::CT_IDLE;
         end
         default: begin
            ctrl_in = kald_pkg::CT_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = (ctrl_ff == kald_pkg::CT_IDLE);
   end

   always_comb begin
      scan_in     = scan_ff;
      count_in    = count_ff;
      byte_in     = byte_ff;
      eof_in      = eof_ff;
      repass_in   = repass_ff;
      kind_in     = kind_ff;
      len_in      = len_ff;
      rd_idx_in   = rd_idx_ff;
      rdi_in      = rdi_ff;
      rd_valid_in = rd_valid_ff;
      if (pass_go) begin
         scan_in  = p_scan;
         count_in = p_em ? '0 : p_after;
         if (p_em) begin
            kind_in   = p_kind;
            len_in    = p_after;
            repass_in = p_rp;
            rd_idx_in = '0;
         end
      end
      if ((ctrl_ff == kald_pkg::CT_IDLE) && req_tvalid) begin
         byte_in = req_tdata;
         eof_in  = req_tuser;
      end
      if (rd_en) begin
         rd_idx_in   = rd_idx_ff + LW'(1);
         rdi_in      = rd_idx_ff[IW-1:0];
         rd_valid_in = 1'b1;
      end else if (load_mem) begin
         rd_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_byte_in  = out_byte_ff;
      out_idx_in   = out_idx_ff;
      out_len_in   = out_len_ff;
      out_last_in  = out_last_ff;
      if (load_mem) begin
         out_valid_in = 1'b1;
         out_kind_in  = kind_ff;
         out_byte_in  = mem_rdata;
         out_idx_in   = rdi_ff;
         out_len_in   = len_ff;
         out_last_in  = mem_last;
      end else if (load_empty) begin
         out_valid_in = 1'b1;
         out_kind_in  = kind_ff;
         out_byte_in  = '0;
         out_idx_in   = '0;
         out_len_in   = '0;
         out_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff      <= kald_pkg::CT_IDLE;
         scan_ff      <= kald_pkg::SC_START;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         ctrl_ff      <= ctrl_in;
         scan_ff      <= scan_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      eof_ff      <= eof_in;
      repass_ff   <= repass_in;
      kind_ff     <= kind_in;
      len_ff      <= len_in;
      rd_idx_ff   <= rd_idx_in;
      rdi_ff      <= rdi_in;
      out_kind_ff <= out_kind_in;
      out_byte_ff <= out_byte_in;
      out_idx_ff  <= out_idx_in;
      out_len_ff  <= out_len_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {5'b0, 6'(out_len_ff), 5'(out_idx_ff), out_byte_ff};

`ifndef SYNTHESIS
   a_rd_in_emit : assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (ctrl_ff == kald_pkg::CT_EMIT))
      else $error("lexeme read pending outside emission");

   a_count_clamp : assert property (@(posedge clock) disable iff (reset)
      count_ff <= LW'(kald_pkg::MAX_LEXEME))
      else $error("lexeme count beyond clamp");

   a_no_wr_emit : assert property (@(posedge clock) disable iff (reset)
      (ctrl_ff == kald_pkg::CT_EMIT) |-> !lex_wr.wr)
      else $error("lexeme store written while streaming");

   a_mid_token : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (ctrl_ff == kald_pkg::CT_EMIT))
      else $error("token left unfinished");
`endif

endmodule
